// ----- hw/rtl/icdf_pkg.sv -----
// Shared constants and helpers for the inverse-CDF table sampler.
// No dependencies; used by inverse_cdf_table_sampler_unit.
package icdf_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = 8;
    localparam int VAL_W       = 32;
    localparam int CDF_W       = 32;
    localparam int IN_DATA_W   = 104;
    localparam int OUT_DATA_W  = 40;
    localparam int CNT_W       = 5;

    // One table entry: value in the upper half, CDF point in the lower half.
    typedef logic [VAL_W+CDF_W-1:0] t_entry;
    typedef logic [ADDR_W-1:0]      t_addr;

    // Map the 8-bit entry index onto a table address.
    function automatic t_addr idx_to_addr(input logic [IDX_W-1:0] idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[ADDR_W-1:0];
    endfunction

    // True when the entry index lands inside the table.
    function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(TABLE_DEPTH);
    endfunction

    // Table address reported as an 8-bit bin number.
    function automatic logic [IDX_W-1:0] addr_to_bin(input t_addr a);
        logic [31:0] w;
        w = 32'(a);
        return w[IDX_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/inverse_cdf_table_sampler_unit.sv -----
// Inverse-CDF table sampler: table memory, bisection search, serial divider
// and interpolation. Depends on icdf_pkg.
//
// Usage: the slave channel carries two kinds of items, selected by
// i_s_tuser. A load item (tuser = 0) writes one table entry (value and CDF
// point) at entry_index and produces no result. A sample
// item (tuser = 1) carries a Q0.32 probability. The block bisects the CDF
// table, one entry read per step, until adjacent bins lo and hi remain
// (cdf[mid] < prob moves lo up, else hi down), then reads both bracketing
// entries, runs a restoring divider one quotient bit per cycle to form
// the interpolation fraction, multiplies once and rounds.
// A sample's result is registered after the search on the single read port,
// both bracketing reads, the divider steps, the multiply and the final state;
// with no span between the bracketing CDF points, divider and multiply are skipped.
// One item is in work at a time; o_s_tready is high only in the idle state.
// The result sits in an output register on the master channel, so a stalled
// receiver holds the result there while the block already takes the next
// item; a new result waits in its final state until the register is free.
// Reset clears the sequencer and the output valid flag. Table contents are
// not cleared: every entry must be loaded before a sample reads it.
module inverse_cdf_table_sampler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: entry_index[7:0], entry_value[39:8], entry_cdf[71:40], prob[103:72]
    input  logic [icdf_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: func (0 = load entry, 1 = sample)
    input  logic        i_s_tuser,
    // Master channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: sample_value[31:0], bin_low[39:32]
    output logic [icdf_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // tuser: zero_span
    output logic        o_m_tuser
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SRCH_RD  = 4'd1;
    localparam logic [3:0] S_SRCH_CMP = 4'd2;
    localparam logic [3:0] S_RD_LO    = 4'd3;
    localparam logic [3:0] S_RD_HI    = 4'd4;
    localparam logic [3:0] S_PREP     = 4'd5;
    localparam logic [3:0] S_DIV      = 4'd6;
    localparam logic [3:0] S_MUL      = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;

    localparam int AW = icdf_pkg::ADDR_W;
    localparam int VW = icdf_pkg::VAL_W;
    localparam int CW = icdf_pkg::CDF_W;

    // Input field extraction
    logic [icdf_pkg::IDX_W-1:0] s_idx;
    logic [VW-1:0]              s_val;
    logic [CW-1:0]              s_cdf;
    logic [CW-1:0]              s_prob;
    logic                       s_in_acc;

    assign s_idx    = i_s_tdata[7:0];
    assign s_val    = i_s_tdata[39:8];
    assign s_cdf    = i_s_tdata[71:40];
    assign s_prob   = i_s_tdata[103:72];
    assign s_in_acc = i_s_tvalid && o_s_tready;

    // Sequencer and datapath registers
    logic [3:0]          r_state, n_state;
    icdf_pkg::t_addr     r_lo, n_lo;
    icdf_pkg::t_addr     r_hi, n_hi;
    icdf_pkg::t_addr     r_mid, n_mid;
    logic [CW-1:0]       r_prob, n_prob;
    logic [CW-1:0]       r_c_lo, n_c_lo;
    logic [VW-1:0]       r_v_lo, n_v_lo;
    logic [CW-1:0]       r_span, n_span;
    logic [CW:0]         r_rem, n_rem;
    logic [CW:0]         r_quot, n_quot;
    logic [icdf_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [VW-1:0]       r_mag, n_mag;
    logic                r_neg, n_neg;
    logic                r_zs, n_zs;
    logic [2*VW-1:0]     r_prod, n_prod;
    logic                r_ovalid, n_ovalid;
    logic [icdf_pkg::OUT_DATA_W-1:0] r_odata, n_odata;
    logic                r_ouser, n_ouser;

    // Table memory with registered read
    icdf_pkg::t_entry    r_mem [icdf_pkg::TABLE_DEPTH];
    icdf_pkg::t_entry    r_rd_data;
    icdf_pkg::t_addr     rd_addr;

    always_ff @(posedge i_clk) begin
        if (s_in_acc && !i_s_tuser && icdf_pkg::idx_in_range(s_idx)) begin
            r_mem[icdf_pkg::idx_to_addr(s_idx)] <= {s_val, s_cdf};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Combinational helpers
    logic [AW:0]   mid_sum;
    icdf_pkg::t_addr lo_hi_gap;
    logic          out_free;
    logic [CW-1:0] rd_cdf;
    logic [VW-1:0] rd_val;
    logic [CW-1:0] pn;
    logic [VW:0]   delta;
    logic [CW:0]   rem_sh;
    logic [VW:0]   off;
    logic [VW:0]   res;
    logic [2*VW-1:0] prod_rnd;

    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign lo_hi_gap = r_hi - r_lo;
    assign out_free  = !r_ovalid || i_m_tready;
    assign rd_cdf    = r_rd_data[CW-1:0];
    assign rd_val    = r_rd_data[VW+CW-1:CW];
    assign pn        = r_prob - r_c_lo;
    assign delta     = {rd_val[VW-1], rd_val} - {r_v_lo[VW-1], r_v_lo};
    assign rem_sh    = {r_rem[CW-1:0], 1'b0};
    assign prod_rnd  = r_prod + {{VW{1'b0}}, 1'b1, {(VW-1){1'b0}}};
    assign off       = r_quot[CW] ? {1'b0, r_mag} : {1'b0, prod_rnd[2*VW-1:VW]};
    assign res       = r_neg ? ({r_v_lo[VW-1], r_v_lo} - off)
                             : ({r_v_lo[VW-1], r_v_lo} + off);

    always_comb begin
        case (r_state)
            S_SRCH_RD: rd_addr = mid_sum[AW:1];
            S_RD_LO:   rd_addr = r_lo;
            default:   rd_addr = r_hi;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_prob   = r_prob;
        n_c_lo   = r_c_lo;
        n_v_lo   = r_v_lo;
        n_span   = r_span;
        n_rem    = r_rem;
        n_quot   = r_quot;
        n_cnt    = r_cnt;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_zs     = r_zs;
        n_prod   = r_prod;
        n_ovalid = r_ovalid && !i_m_tready;
        n_odata  = r_odata;
        n_ouser  = r_ouser;

        case (r_state)
            S_IDLE: begin
                if (s_in_acc && i_s_tuser) begin
                    n_prob  = s_prob;
                    n_lo    = '0;
                    n_hi    = AW'(icdf_pkg::TABLE_DEPTH - 1);
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                // Keep halving until the bracket is one bin wide.
                if (lo_hi_gap > AW'(1)) begin
                    n_mid   = mid_sum[AW:1];
                    n_state = S_SRCH_CMP;
                end else begin
                    n_state = S_RD_LO;
                end
            end
            S_SRCH_CMP: begin
                if (rd_cdf < r_prob) begin
                    n_lo = r_mid;
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_SRCH_RD;
            end
            S_RD_LO: begin
                n_state = S_RD_HI;
            end
            S_RD_HI: begin
                n_c_lo  = rd_cdf;
                n_v_lo  = rd_val;
                n_state = S_PREP;
            end
            S_PREP: begin
                // Read data now holds the upper bracketing entry.
                n_span = rd_cdf - r_c_lo;
                n_neg  = delta[VW];
                n_mag  = delta[VW] ? VW'(-delta) : delta[VW-1:0];
                if (rd_cdf <= r_c_lo) begin
                    n_zs    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_zs = 1'b0;
                    // Clamped numerator equals the span: the fraction is one.
                    if (r_prob > r_c_lo && pn >= (rd_cdf - r_c_lo)) begin
                        n_rem  = '0;
                        n_quot = {{CW{1'b0}}, 1'b1};
                    end else begin
                        n_rem  = (r_prob > r_c_lo) ? {1'b0, pn} : '0;
                        n_quot = '0;
                    end
                    n_cnt   = '1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // One restoring-division step per cycle.
                if (rem_sh >= {1'b0, r_span}) begin
                    n_rem  = rem_sh - {1'b0, r_span};
                    n_quot = {r_quot[CW-1:0], 1'b1};
                end else begin
                    n_rem  = rem_sh;
                    n_quot = {r_quot[CW-1:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_state = S_MUL;
                end
                n_cnt = r_cnt - 1'b1;
            end
            S_MUL: begin
                n_prod  = (2*VW)'(r_mag) * (2*VW)'(r_quot[CW-1:0]);
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = {icdf_pkg::addr_to_bin(r_lo),
                                r_zs ? r_v_lo : res[VW-1:0]};
                    n_ouser  = r_zs;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_prob  <= n_prob;
        r_c_lo  <= n_c_lo;
        r_v_lo  <= n_v_lo;
        r_span  <= n_span;
        r_rem   <= n_rem;
        r_quot  <= n_quot;
        r_cnt   <= n_cnt;
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_zs    <= n_zs;
        r_prod  <= n_prod;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    // A sample item starts the search in the very next cycle.
    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_acc && i_s_tuser |=> r_state == S_SRCH_RD)
        else $error("sample item did not start the search");

    // The search bracket never collapses or inverts.
    a_bracket_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH_RD || r_state == S_SRCH_CMP) |-> r_lo < r_hi)
        else $error("search bracket inverted");

    // A full fraction leaves no lower quotient bits.
    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) && r_quot[CW] |-> r_quot[CW-1:0] == '0)
        else $error("interpolation fraction above one");

    // A new result only appears from the final state.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_FIN)
        else $error("result produced outside final state");

endmodule

// ----- test/inverse_cdf_table_sampler_unit_tb.sv -----
// Self-checking testbench for inverse_cdf_table_sampler_unit: table loads, samples and
// interpolation are predicted in the bench and compared with every result item.
// Depends on icdf_pkg and the unit's RTL; needs no other files.
`timescale 1ns / 100ps

module testbench;

    // Kind of input item, carried on i_s_tuser.
    typedef enum bit {
        FUNC_LOAD   = 1'b0,
        FUNC_SAMPLE = 1'b1
    } t_func;

    // One result item as it leaves the block.
    typedef struct packed {
        bit [31:0] value;
        bit [7:0]  bin;
        bit        zero_span;
    } t_sample;

    // One row of the directed stimulus. When typed is set, want holds the
    // result read off the table by hand; otherwise the predictor supplies it.
    typedef struct packed {
        t_func     func;
        bit [7:0]  idx;
        bit [31:0] value;
        bit [31:0] cdf;
        bit [31:0] prob;
        bit        typed;
        t_sample   want;
    } t_dir_row;

    localparam t_sample NO_WANT   = '{32'h0, 8'h0, 1'b0};
    localparam int      HOLD_LEN  = 600;  // long receiver hold-off, in cycles
    localparam int      DRAIN_LEN = 80;   // a bit more than one sample's latency

    logic                              clk;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    // entry_index[7:0], entry_value[39:8], entry_cdf[71:40], prob[103:72]
    logic [icdf_pkg::IN_DATA_W-1:0]    s_tdata;
    // func
    logic                              s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    // sample_value[31:0], bin_low[39:32]
    logic [icdf_pkg::OUT_DATA_W-1:0]   m_tdata;
    // zero_span
    logic                              m_tuser;

    // Bench copy of the table, kept in step with every accepted load item.
    bit [31:0] cdf_mem [icdf_pkg::TABLE_DEPTH];
    bit [31:0] val_mem [icdf_pkg::TABLE_DEPTH];

    t_sample   pending_samples[$];
    t_dir_row  dir_rows[$];
    int        mismatches;
    int        tx_idle_pct;
    int        rx_stall_pct;
    bit        hold_request;

    inverse_cdf_table_sampler_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Bisect the CDF to the bracketing bin, then interpolate the value in
    // Q15.16 with the Q0.32 fraction, rounding the offset half up.
    function automatic t_sample interpolate_sample(input bit [31:0] p);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        bit [31:0]   c_lo;
        bit [31:0]   c_hi;
        bit [31:0]   span;
        bit [31:0]   num;
        longint      v_lo;
        longint      v_hi;
        longint      delta;
        longint      res;
        bit [63:0]   mag;
        bit [63:0]   frac;
        bit [63:0]   off;
        t_sample     s;
        lo = 0;
        hi = icdf_pkg::TABLE_DEPTH - 1;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (cdf_mem[mid] < p)
                lo = mid;
            else
                hi = mid;
        end
        c_lo  = cdf_mem[lo];
        c_hi  = cdf_mem[hi];
        s.bin = lo[7:0];
        // Equal or decreasing bracketing entries: no interpolation at all.
        if (c_hi <= c_lo) begin
            s.value     = val_mem[lo];
            s.zero_span = 1'b1;
            return s;
        end
        span = c_hi - c_lo;
        // Probabilities outside the bracket clamp to its ends.
        if (p <= c_lo)
            num = 32'd0;
        else if (p - c_lo >= span)
            num = span;
        else
            num = p - c_lo;
        frac  = {num, 32'd0} / {32'd0, span};
        v_lo  = longint'($signed(val_mem[lo]));
        v_hi  = longint'($signed(val_mem[hi]));
        delta = v_hi - v_lo;
        mag   = (delta < 0) ? 64'(-delta) : 64'(delta);
        off   = (mag * frac + 64'h8000_0000) >> 32;
        res   = (delta < 0) ? v_lo - longint'(off) : v_lo + longint'(off);
        s.value     = res[31:0];
        s.zero_span = 1'b0;
        return s;
    endfunction

    // Offer one item, wait for the handshake, then update the table copy or
    // queue the expected result.
    task automatic offer_item(input t_func f, input bit [7:0] idx, input bit [31:0] value,
                              input bit [31:0] cdf, input bit [31:0] p,
                              input bit typed, input t_sample want);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {p, cdf, value, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (f == FUNC_LOAD) begin
            if (int'(idx) < icdf_pkg::TABLE_DEPTH) begin
                val_mem[idx] = value;
                cdf_mem[idx] = cdf;
            end
        end else begin
            pending_samples.push_back(typed ? want : interpolate_sample(p));
        end
    endtask

    // Random item: mostly samples and loads that keep the CDF in order,
    // with some loads that break it.
    task automatic offer_random_item();
        int          pick;
        int          k;
        bit [7:0]    idx;
        bit [31:0]   lo_b;
        bit [31:0]   hi_b;
        bit [31:0]   cdf;
        bit [31:0]   p;
        pick = $urandom_range(99);
        idx  = 8'($urandom_range(255));
        cdf  = $urandom;
        p    = $urandom;
        if (pick < 60) begin
            k = $urandom_range(9);
            if (k == 0)
                p = 32'h0;
            else if (k == 1)
                p = 32'hFFFF_FFFF;
            else if (k < 4)
                p = cdf_mem[$urandom_range(255)] + 32'($urandom_range(2)) - 32'd1;
            offer_item(FUNC_SAMPLE, idx, $urandom, cdf, p, 1'b0, NO_WANT);
        end else begin
            if (pick < 90) begin
                lo_b = (idx == 8'd0)   ? 32'h0         : cdf_mem[idx - 8'd1];
                hi_b = (idx == 8'd255) ? 32'hFFFF_FFFF : cdf_mem[idx + 8'd1];
                if (lo_b <= hi_b) begin
                    k = $urandom_range(3);
                    cdf = (k == 0) ? lo_b : (k == 1) ? hi_b : $urandom_range(hi_b, lo_b);
                end
            end
            offer_item(FUNC_LOAD, idx, $urandom, cdf, p, 1'b0, NO_WANT);
        end
    endtask

    task automatic check_sample_result();
        t_sample want;
        if (pending_samples.size() == 0) begin
            note_mismatch($sformatf("unexpected result item %h/%b", m_tdata, m_tuser));
            return;
        end
        want = pending_samples.pop_front();
        if (m_tdata[31:0] !== want.value)
            note_mismatch($sformatf("sample_value %h, expected %h", m_tdata[31:0], want.value));
        if (m_tdata[39:32] !== want.bin)
            note_mismatch($sformatf("bin_low %0d, expected %0d", m_tdata[39:32], want.bin));
        if (m_tuser !== want.zero_span)
            note_mismatch($sformatf("zero_span %b, expected %b", m_tuser, want.zero_span));
    endtask

    // Receiver: checks every accepted result item and drives the stalls,
    // including the long hold-off that lets the block back up.
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_sample_result();
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_LEN;
                m_tready    <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        int idle_tx [4];
        int idle_rx [4];
        idle_tx = '{0, 77, 0, 23};
        idle_rx = '{0, 0, 77, 23};
        mismatches   = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= FUNC_LOAD;
        s_tdata  <= '0;

        // The directed rows assume the ramp table loaded below:
        // cdf[i] = i << 24 and value[i] = (i - 128) << 16.
        dir_rows.push_back('{FUNC_SAMPLE, 8'd0, 32'h0, 32'h0, 32'h0000_0000, 1'b1,
                             '{32'hFF80_0000, 8'd0, 1'b0}});
        dir_rows.push_back('{FUNC_SAMPLE, 8'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1,
                             '{32'h007F_0000, 8'd254, 1'b0}});
        dir_rows.push_back('{FUNC_SAMPLE, 8'd0, 32'h0, 32'h0, 32'h0100_0000, 1'b1,
                             '{32'hFF81_0000, 8'd0, 1'b0}});
        dir_rows.push_back('{FUNC_SAMPLE, 8'd0, 32'h0, 32'h0, 32'h0080_0000, 1'b1,
                             '{32'hFF80_8000, 8'd0, 1'b0}});
        dir_rows.push_back('{FUNC_SAMPLE, 8'd0, 32'h0, 32'h0, 32'h7F80_0000, 1'b0, NO_WANT});
        // Equal first two CDF points with prob zero: no span to interpolate.
        dir_rows.push_back('{FUNC_LOAD, 8'd1, 32'h0005_0000, 32'h0, 32'h0, 1'b0, NO_WANT});
        dir_rows.push_back('{FUNC_SAMPLE, 8'd0, 32'h0, 32'h0, 32'h0000_0000, 1'b1,
                             '{32'hFF80_0000, 8'd0, 1'b1}});
        // Equal last two CDF points, then a decreasing last point.
        dir_rows.push_back('{FUNC_LOAD, 8'd255, 32'h7FFF_FFFF, 32'hFE00_0000, 32'h0, 1'b0,
                             NO_WANT});
        dir_rows.push_back('{FUNC_SAMPLE, 8'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1,
                             '{32'h007E_0000, 8'd254, 1'b1}});
        dir_rows.push_back('{FUNC_LOAD, 8'd255, 32'h8000_0000, 32'h0000_0005, 32'h0, 1'b0,
                             NO_WANT});
        dir_rows.push_back('{FUNC_SAMPLE, 8'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1,
                             '{32'h007E_0000, 8'd254, 1'b1}});
        // Extreme values at both ends of the table.
        dir_rows.push_back('{FUNC_LOAD, 8'd255, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0,
                             NO_WANT});
        dir_rows.push_back('{FUNC_LOAD, 8'd254, 32'h8000_0000, 32'hFE00_0000, 32'h0, 1'b0,
                             NO_WANT});
        dir_rows.push_back('{FUNC_SAMPLE, 8'd0, 32'h0, 32'h0, 32'hFF00_0000, 1'b0, NO_WANT});
        dir_rows.push_back('{FUNC_LOAD, 8'd0, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, NO_WANT});
        dir_rows.push_back('{FUNC_LOAD, 8'd1, 32'h8000_0000, 32'h0100_0000, 32'h0, 1'b0,
                             NO_WANT});
        dir_rows.push_back('{FUNC_SAMPLE, 8'd0, 32'h0, 32'h0, 32'h0000_0001, 1'b0, NO_WANT});
        dir_rows.push_back('{FUNC_SAMPLE, 8'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1,
                             '{32'h7FFF_FFFF, 8'd254, 1'b0}});
        // Prob exactly on a CDF point lands at the top of the lower bin.
        dir_rows.push_back('{FUNC_LOAD, 8'd128, 32'h0, 32'h8000_0000, 32'h0, 1'b0, NO_WANT});
        dir_rows.push_back('{FUNC_SAMPLE, 8'd0, 32'h0, 32'h0, 32'h8000_0000, 1'b1,
                             '{32'h0000_0000, 8'd127, 1'b0}});
        dir_rows.push_back('{FUNC_SAMPLE, 8'd0, 32'h0, 32'h0, 32'h8000_0001, 1'b0, NO_WANT});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Every entry is written before the first sample can read it.
        for (int i = 0; i < icdf_pkg::TABLE_DEPTH; i++)
            offer_item(FUNC_LOAD, 8'(i), 32'(i - 128) << 16, 32'(i) << 24, $urandom,
                       1'b0, NO_WANT);

        foreach (dir_rows[r])
            offer_item(dir_rows[r].func, dir_rows[r].idx, dir_rows[r].value,
                       dir_rows[r].cdf, dir_rows[r].prob, dir_rows[r].typed,
                       dir_rows[r].want);

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = idle_tx[ph];
            rx_stall_pct = idle_rx[ph];
            if (ph == 0)
                hold_request = 1'b1;
            for (int n = 0; n < 50; n++)
                offer_random_item();
        end
        s_tvalid <= 1'b0;

        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_LEN) @(posedge clk);

        if (mismatches == 0 && pending_samples.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
